[hw/rtl/tlpf_pkg.sv]
// shared constants, types and status codes for the three-level priority fifo
// no dependencies; imported by the channel interfaces, tlpf_level_ctrl and the top level
`default_nettype none

package tlpf_pkg;

  localparam int DEPTH  = 16;
  localparam int LEVELS = 3;

  localparam int VAL_W  = 32;
  localparam int PRIO_W = 2;
  localparam int STAT_W = 2;
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(LEVELS * DEPTH);
  localparam int WIDE_W = PRIO_W + LVL_W + 1;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic signed [VAL_W-1:0] EMPTY_VALUE = -32'sd1;
  localparam logic signed [VAL_W-1:0] ENQ_VALUE   = 32'sd0;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // memory operation for one accepted transaction
  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] status;
  } tlpf_op_t;

endpackage

`default_nettype wire

[hw/rtl/tlpf_chan_if.sv]
// valid/ready channel interfaces for the request and result sides
// depends on tlpf_pkg for field widths
`default_nettype none

interface tlpf_in_if;
  import tlpf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [PRIO_W-1:0]         priority_level;
  logic signed [VAL_W-1:0]   item_value;

  modport source (output valid, action, priority_level, item_value, input ready);
  modport sink   (input valid, action, priority_level, item_value, output ready);
endinterface

interface tlpf_out_if;
  import tlpf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VAL_W-1:0]   popped_value;
  logic [STAT_W-1:0]         status;

  modport source (output valid, popped_value, status, input ready);
  modport sink   (input valid, popped_value, status, output ready);
endinterface

`default_nettype wire

[hw/rtl/tlpf_entry_ram.sv]
// generic single-port synchronous ram with registered read data
// no package dependencies
`default_nettype none

module tlpf_entry_ram #(
  parameter int WORDS  = 48,
  parameter int DATA_W = 32,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tlpf_level_ctrl.sv]
// per-level ring pointers and counts; picks the level and ram address
// depends on tlpf_pkg
`default_nettype none

module tlpf_level_ctrl
  import tlpf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic              action,
  input  wire logic [PRIO_W-1:0] prio,
  output tlpf_op_t               op
);

  logic [PTR_W-1:0] head_r [LEVELS];
  logic [PTR_W-1:0] tail_r [LEVELS];
  logic [CNT_W-1:0] cnt_r  [LEVELS];

  logic [LVL_W-1:0] enq_lvl;
  logic [LVL_W-1:0] deq_lvl;
  logic             any_held;
  logic             enq_full;
  logic [WIDE_W-1:0] prio_wide;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] ram_addr(input logic [LVL_W-1:0] l,
                                                 input logic [PTR_W-1:0] p);
    return ADDR_W'(l) * ADDR_W'(DEPTH) + ADDR_W'(p);
  endfunction

  // out-of-range priority goes to the lowest level
  always_comb begin
    prio_wide = WIDE_W'(prio);
    if (prio_wide >= WIDE_W'(1) && prio_wide <= WIDE_W'(LEVELS)) begin
      enq_lvl = LVL_W'(prio_wide - WIDE_W'(1));
    end else begin
      enq_lvl = LVL_W'(LEVELS - 1);
    end
  end

  // lowest index with entries wins
  always_comb begin
    deq_lvl  = '0;
    any_held = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        deq_lvl  = LVL_W'(i);
        any_held = 1'b1;
      end
    end
  end

  assign enq_full = (cnt_r[enq_lvl] >= CNT_FULL);

  always_comb begin
    op = '0;
    unique case (action)
      ACT_ENQ: begin
        op.addr   = ram_addr(enq_lvl, tail_r[enq_lvl]);
        op.wr     = accept && !enq_full;
        op.status = enq_full ? ST_FULL : ST_OK;
      end
      ACT_DEQ: begin
        op.addr   = ram_addr(deq_lvl, head_r[deq_lvl]);
        op.rd     = accept && any_held;
        op.status = any_held ? ST_OK : ST_EMPTY;
      end
      default: begin
        op = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (op.wr) begin
      tail_r[enq_lvl] <= ring_next(tail_r[enq_lvl]);
      cnt_r[enq_lvl]  <= cnt_r[enq_lvl] + CNT_W'(1);
    end else if (op.rd) begin
      head_r[deq_lvl] <= ring_next(head_r[deq_lvl]);
      cnt_r[deq_lvl]  <= cnt_r[deq_lvl] - CNT_W'(1);
    end
  end

`ifndef SYNTHESIS
  logic cnt_over;
  always_comb begin
    cnt_over = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      if (cnt_r[i] > CNT_FULL) cnt_over = 1'b1;
    end
  end

  a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(op.wr && op.rd)) else $error("ram read and write in one cycle");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !cnt_over) else $error("level count above depth");
  a_ops_need_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (op.wr || op.rd) |-> accept) else $error("ram access without transaction");
`endif

endmodule

`default_nettype wire

[hw/rtl/three_level_priority_fifo_unit.sv]
// top level of the strict-priority multi-level fifo
// depends on tlpf_pkg, tlpf_chan_if, tlpf_level_ctrl and tlpf_entry_ram
//
// usage:
//   in_ch  (sink): action 0 enqueues item_value at priority_level (1 highest,
//          0 or out of range maps to the lowest level); action 1 dequeues the
//          head of the highest-priority non-empty level
//   out_ch (source): one result per request transaction, in order;
//          popped_value/status = value/ok, -1/empty, 0/ok, or 0/full
//   path: an accepted request is registered in stage 1, then in the output register
//   throughput: one transaction per cycle while out_ch keeps taking results;
//          set by the single ram port, one read or one write per request
//   rst_n (synchronous, active low) empties every level; stored data is not
//          cleared, no clearing pass is needed
//   stall: a held result and one request in flight are kept; in_ch.ready
//          drops once both stages are full and out_ch.ready is low
`default_nettype none

module three_level_priority_fifo_unit
  import tlpf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  tlpf_in_if.sink    in_ch,
  tlpf_out_if.source out_ch
);

  tlpf_op_t          op;
  logic              accept;
  logic              s1_adv;
  logic [VAL_W-1:0]  rd_data;

  logic              s1_valid_r;
  logic              s1_read_r;
  logic [STAT_W-1:0] s1_status_r;
  logic              out_valid_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic [STAT_W-1:0] out_status_r;
  logic signed [VAL_W-1:0] s1_value;

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;

  tlpf_level_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .action (in_ch.action),
    .prio   (in_ch.priority_level),
    .op     (op)
  );

  tlpf_entry_ram #(
    .WORDS  (LEVELS * DEPTH),
    .DATA_W (VAL_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .en    (op.wr || op.rd),
    .we    (op.wr),
    .addr  (op.addr),
    .wdata (in_ch.item_value),
    .rdata (rd_data)
  );

  // ram read data holds until the next read, which needs stage 1 to move on
  always_comb begin
    priority if (s1_read_r) begin
      s1_value = $signed(rd_data);
    end else if (s1_status_r == ST_EMPTY) begin
      s1_value = EMPTY_VALUE;
    end else begin
      s1_value = ENQ_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_read_r   <= op.rd;
      s1_status_r <= op.status;
    end
    if (s1_adv && s1_valid_r) begin
      out_value_r  <= s1_value;
      out_status_r <= s1_status_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = out_value_r;
  assign out_ch.status       = out_status_r;

`ifndef SYNTHESIS
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready) else $error("request stalled with no result held");
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r) else $error("accepted transaction lost");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ST_OK || out_status_r == ST_EMPTY ||
                     out_status_r == ST_FULL)) else $error("bad result status");
  a_read_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_read_r) |-> (s1_status_r == ST_OK))
    else $error("ram read with non-ok status");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_three_level_priority_fifo_unit.sv]
// self-checking testbench for the three-level strict-priority fifo unit
// drives tlpf_in_if, checks tlpf_out_if against a shadow of the level rings
// depends on tlpf_pkg, tlpf_chan_if and three_level_priority_fifo_unit
`timescale 1ns / 1ps

module tb_three_level_priority_fifo_unit;
  import tlpf_pkg::*;

  localparam int HANG_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int IDLE_PCT    = 38;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic signed [VAL_W-1:0] popped_value;
    logic [STAT_W-1:0]       status;
  } fifo_result_t;

  logic clk;
  logic rst_n;

  tlpf_in_if  in_if ();
  tlpf_out_if out_if ();

  three_level_priority_fifo_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // shadow copy of the level rings
  logic signed [VAL_W-1:0] shadow_store [LEVELS][DEPTH];
  logic [PTR_W-1:0]        shadow_head  [LEVELS];
  logic [PTR_W-1:0]        shadow_tail  [LEVELS];
  logic [CNT_W-1:0]        shadow_count [LEVELS];

  fifo_result_t pending_results[$];
  int           error_count;
  int           stall_cycles;
  bit           no_idle;
  bit           hold_request;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic fifo_result_t predict_queue_op(input logic act,
                                                    input logic [PRIO_W-1:0] prio,
                                                    input logic signed [VAL_W-1:0] val);
    fifo_result_t res;
    int           lvl;
    res.popped_value = ENQ_VALUE;
    res.status       = ST_OK;
    if (act == ACT_ENQ) begin
      // priority 0 or above LEVELS lands in the lowest level
      lvl = (int'(prio) >= 1 && int'(prio) <= LEVELS) ? int'(prio) - 1 : LEVELS - 1;
      if (shadow_count[lvl] == CNT_FULL) begin
        res.status = ST_FULL;
      end else begin
        shadow_store[lvl][shadow_tail[lvl]] = val;
        shadow_tail[lvl]  = (shadow_tail[lvl] == PTR_LAST) ? '0 :
                            shadow_tail[lvl] + PTR_W'(1);
        shadow_count[lvl] = shadow_count[lvl] + CNT_W'(1);
      end
      return res;
    end
    for (lvl = 0; lvl < LEVELS; lvl++) begin
      if (shadow_count[lvl] != '0) begin
        res.popped_value  = shadow_store[lvl][shadow_head[lvl]];
        shadow_head[lvl]  = (shadow_head[lvl] == PTR_LAST) ? '0 :
                            shadow_head[lvl] + PTR_W'(1);
        shadow_count[lvl] = shadow_count[lvl] - CNT_W'(1);
        return res;
      end
    end
    res.popped_value = EMPTY_VALUE;
    res.status       = ST_EMPTY;
    return res;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic act, input logic [PRIO_W-1:0] prio,
                           input logic signed [VAL_W-1:0] val);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.action         <= act;
    in_if.priority_level <= prio;
    in_if.item_value     <= val;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(predict_queue_op(act, prio, val));
  endtask

  task automatic send_random(input int enq_pct);
    logic act;
    act = ($urandom_range(99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
    send_item(act, PRIO_W'($urandom_range(3)), pick_value());
  endtask

  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // empty dequeue, every priority code, extreme values, strict ordering
  task automatic test_priority_order();
    send_item(ACT_DEQ, 2'd3, '1);
    send_item(ACT_ENQ, 2'd3, 32'sh7fff_ffff);
    send_item(ACT_ENQ, 2'd0, 32'sh8000_0000);
    send_item(ACT_ENQ, 2'd2, '1);
    send_item(ACT_ENQ, 2'd1, '0);
    repeat (5) send_item(ACT_DEQ, 2'd0, 32'sh5a5a_a5a5);
  endtask

  // fill every level past full, then drain everything plus one empty dequeue
  task automatic test_level_full();
    for (int p = 1; p <= LEVELS; p++) begin
      for (int i = 0; i <= DEPTH; i++) begin
        if (p == LEVELS && i[0])
          send_item(ACT_ENQ, 2'd0, pick_value());
        else
          send_item(ACT_ENQ, PRIO_W'(p), pick_value());
      end
    end
    repeat (LEVELS * DEPTH + 1) send_item(ACT_DEQ, PRIO_W'($urandom_range(3)), pick_value());
  endtask

  // receiver stalls for a long stretch while transactions keep coming
  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (30) send_random(60);
    // sender pause until the block has returned everything
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    int enq_mix [8] = '{90, 50, 15, 70, 30, 95, 50, 10};
    for (int ph = 0; ph < 8; ph++) begin
      no_idle = (ph == 3);
      repeat (145) send_random(enq_mix[ph]);
    end
    no_idle = 1'b0;
  endtask

  task automatic check_result();
    fifo_result_t exp_res;
    if (pending_results.size() == 0) begin
      $error("unexpected result: popped_value %0d status %0d",
             out_if.popped_value, out_if.status);
      error_count++;
      return;
    end
    exp_res = pending_results.pop_front();
    if (out_if.popped_value !== exp_res.popped_value) begin
      $error("popped_value: expected %0d, got %0d", exp_res.popped_value, out_if.popped_value);
      error_count++;
    end
    if (out_if.status !== exp_res.status) begin
      $error("status: expected %0d, got %0d", exp_res.status, out_if.status);
      error_count++;
    end
  endtask

  // result side: checks each transaction and drives ready
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) check_result();
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= HANG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    error_count  = 0;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      shadow_head[l]  = '0;
      shadow_tail[l]  = '0;
      shadow_count[l] = '0;
    end
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.action         <= ACT_ENQ;
    in_if.priority_level <= '0;
    in_if.item_value     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_priority_order();
    test_level_full();
    test_backpressure();
    test_random_traffic();

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
